FILE: design/icpb_pkg.sv
`default_nettype none

package icpb_pkg;

    localparam int ACC_BITS      = 16;
    localparam int BIN_BITS      = 8;
    localparam int NCH_BITS      = 5;
    localparam int CC_BITS       = 4;
    localparam int POS_BITS      = 12;
    localparam int SIZE_BITS     = 13;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [SIZE_BITS-1:0] MAX_LINE_ITEMS = 13'd4096;

    localparam logic [BIN_BITS-1:0]  RST_BINNING  = 8'd1;
    localparam logic [CC_BITS-1:0]   RST_CHANNELS = 4'd2;
    localparam logic [SIZE_BITS-1:0] RST_PIXELS   = 13'd512;
    localparam logic [SIZE_BITS-1:0] RST_LINES    = 13'd512;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BINNING_FACTOR  = 2'd0,
        CFG_CHANNEL_COUNT   = 2'd1,
        CFG_PIXELS_PER_LINE = 2'd2,
        CFG_LINES_PER_FRAME = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_ACC
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic stall;
    } t_status;

endpackage

`default_nettype wire

FILE: design/icpb_ctrl.sv
`default_nettype none

module icpb_ctrl
    import icpb_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam int STEP_W = $clog2(SAMPLE_BITS);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step;
    logic              step_last;

    assign step_last = (r_step == STEP_W'(SAMPLE_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DIV) begin
                r_step <= r_step + STEP_W'(1);
            end else begin
                r_step <= '0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (step_last) n_state = ST_ACC;
            end
            ST_ACC: begin
                if (!i_status.stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd.load   = 1'b0;
        o_cmd.step   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
            end
            ST_ACC: begin
                o_cmd.commit = !i_status.stall;
            end
            default: ;
        endcase
    end

    a_load_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_DIV))
        else $error("load did not start the divider");

    a_div_to_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && step_last) |=> (r_state == ST_ACC))
        else $error("divider did not finish after all steps");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.step, o_cmd.commit}))
        else $error("more than one command at once");

endmodule

`default_nettype wire

FILE: design/icpb_dp.sv
`default_nettype none

module icpb_dp
    import icpb_pkg::*;
#(
    parameter int SAMPLE_BITS  = 16,
    parameter int MAX_CHANNELS = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [SAMPLE_BITS-1:0]   i_sample,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  wire t_cmd                     i_cmd,
    output t_status                       o_status,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [ACC_BITS-1:0]           o_ch1_mean,
    output logic [ACC_BITS-1:0]           o_other_mean,
    output logic                          o_eol,
    output logic                          o_eof
);

    localparam int CH_W = $clog2(MAX_CHANNELS);

    logic [BIN_BITS-1:0]    r_binning;
    logic [CC_BITS-1:0]     r_channels;
    logic [SIZE_BITS-1:0]   r_pixels;
    logic [SIZE_BITS-1:0]   r_lines;

    logic [SAMPLE_BITS-1:0] r_quo;
    logic [BIN_BITS-1:0]    r_rem;

    logic [CH_W-1:0]        r_ch;
    logic [BIN_BITS-1:0]    r_bin;
    logic [POS_BITS-1:0]    r_pix;
    logic [POS_BITS-1:0]    r_line;
    logic [ACC_BITS-1:0]    r_acc1;
    logic [ACC_BITS-1:0]    r_acc2;

    logic [BIN_BITS-1:0]    nbin;
    logic [NCH_BITS-1:0]    nch;
    logic [SIZE_BITS-1:0]   ppl;
    logic [SIZE_BITS-1:0]   lpf;
    logic [BIN_BITS:0]      trial;
    logic                   trial_ge;
    logic [ACC_BITS-1:0]    quotient;
    logic                   ch_last;
    logic                   bin_last;
    logic                   emit;
    logic                   eol;
    logic                   eof;

    // zero limits act as one, oversize limits saturate
    always_comb begin
        nbin = (r_binning == '0) ? BIN_BITS'(1) : r_binning;
        if (r_channels == '0) begin
            nch = NCH_BITS'(1);
        end else if (NCH_BITS'(r_channels) > NCH_BITS'(MAX_CHANNELS)) begin
            nch = NCH_BITS'(MAX_CHANNELS);
        end else begin
            nch = NCH_BITS'(r_channels);
        end
        if (r_pixels == '0) ppl = SIZE_BITS'(1);
        else if (r_pixels > MAX_LINE_ITEMS) ppl = MAX_LINE_ITEMS;
        else ppl = r_pixels;
        if (r_lines == '0) lpf = SIZE_BITS'(1);
        else if (r_lines > MAX_LINE_ITEMS) lpf = MAX_LINE_ITEMS;
        else lpf = r_lines;
    end

    // one restoring step per cycle, quotient shifts in behind the dividend
    assign trial    = {r_rem, r_quo[SAMPLE_BITS-1]};
    assign trial_ge = (trial >= {1'b0, nbin});
    assign quotient = ACC_BITS'(r_quo);

    // "at or beyond" so a shrunk limit ends the run at once
    assign ch_last  = (NCH_BITS'(r_ch) + NCH_BITS'(1)) >= nch;
    assign bin_last = ({1'b0, r_bin} + (BIN_BITS+1)'(1)) >= {1'b0, nbin};
    assign emit     = ch_last && bin_last;
    assign eol      = (SIZE_BITS'(r_pix) + SIZE_BITS'(1)) >= ppl;
    assign eof      = eol && ((SIZE_BITS'(r_line) + SIZE_BITS'(1)) >= lpf);

    assign o_status.stall = emit && o_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_binning  <= RST_BINNING;
            r_channels <= RST_CHANNELS;
            r_pixels   <= RST_PIXELS;
            r_lines    <= RST_LINES;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_BINNING_FACTOR:  r_binning  <= i_cfg_data[BIN_BITS-1:0];
                CFG_CHANNEL_COUNT:   r_channels <= i_cfg_data[CC_BITS-1:0];
                CFG_PIXELS_PER_LINE: r_pixels   <= i_cfg_data[SIZE_BITS-1:0];
                CFG_LINES_PER_FRAME: r_lines    <= i_cfg_data[SIZE_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo <= i_sample;
            r_rem <= '0;
        end else if (i_cmd.step) begin
            r_quo <= {r_quo[SAMPLE_BITS-2:0], trial_ge};
            r_rem <= trial_ge ? BIN_BITS'(trial - {1'b0, nbin}) : trial[BIN_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch   <= '0;
            r_bin  <= '0;
            r_pix  <= '0;
            r_line <= '0;
            r_acc1 <= '0;
            r_acc2 <= '0;
        end else if (i_cmd.commit) begin
            if (ch_last) begin
                r_ch <= '0;
                if (bin_last) begin
                    r_bin  <= '0;
                    r_acc1 <= '0;
                    r_acc2 <= '0;
                    if (eol) begin
                        r_pix  <= '0;
                        r_line <= eof ? '0 : r_line + POS_BITS'(1);
                    end else begin
                        r_pix <= r_pix + POS_BITS'(1);
                    end
                end else begin
                    r_bin <= r_bin + BIN_BITS'(1);
                end
            end else begin
                r_ch <= r_ch + CH_W'(1);
            end
            if (!emit) begin
                if (r_ch == CH_W'(1)) r_acc1 <= r_acc1 + quotient;
                else r_acc2 <= r_acc2 + quotient;
            end
        end
    end

    // output register: the final sample of a pixel is folded in on the way out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.commit && emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && emit) begin
            o_ch1_mean   <= (r_ch == CH_W'(1)) ? r_acc1 + quotient : r_acc1;
            o_other_mean <= (r_ch == CH_W'(1)) ? r_acc2 : r_acc2 + quotient;
            o_eol        <= eol;
            o_eof        <= eof;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && emit) |-> (!o_out_valid || i_out_ready))
        else $error("pending result overwritten");

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && emit) |=> (r_acc1 == '0 && r_acc2 == '0 && o_out_valid))
        else $error("accumulators not cleared after a pixel");

endmodule

`default_nettype wire

FILE: design/interleaved_channel_pixel_binner.sv
// Samples are handled one at a time: idle (accept), SAMPLE_BITS bit-serial restoring
//   divider steps, then accumulate, which stalls while a finished pixel is unaccepted;
//   a new sample is taken only once the last one is through.
// A finished pixel waits in the output register while the next samples are taken.
// Reset (synchronous, active low) clears all positions and accumulators and
//   restores the registers to binning 1, 2 channels, 512 x 512.
`default_nettype none

module interleaved_channel_pixel_binner
    import icpb_pkg::*;
#(
    parameter int SAMPLE_BITS  = 16,
    parameter int MAX_CHANNELS = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [SAMPLE_BITS-1:0] sample_value, rest zero
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [15:0] channel_one_mean, [31:16] other_channels_mean
    output logic [2*ACC_BITS-1:0]                    m_axis_tdata,
    output logic                                     m_axis_tlast,
    // [0] end_of_frame
    output logic                                     m_axis_tuser,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]             i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]            i_cfg_data
);

    t_cmd                cmd;
    t_status             status;
    logic [ACC_BITS-1:0] ch1_mean;
    logic [ACC_BITS-1:0] other_mean;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {other_mean, ch1_mean};

    icpb_ctrl #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    icpb_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_ch1_mean  (ch1_mean),
        .o_other_mean(other_mean),
        .o_eol       (m_axis_tlast),
        .o_eof       (m_axis_tuser)
    );

endmodule

`default_nettype wire
